/* rtl/core/plsd_pkg.sv */
// ----------------------------------------------------------------------------
// plsd_pkg
// Shared types and constants of the PDF literal string decoder.
// ----------------------------------------------------------------------------
package plsd_pkg;

   localparam int DEPTH_BITS = 8;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_EOI      = 3'd1;
   localparam logic [2:0] STATUS_OCTAL    = 3'd2;
   localparam logic [2:0] STATUS_BAD_ESC  = 3'd3;
   localparam logic [2:0] STATUS_NEST     = 3'd4;

   typedef enum logic [3:0] {
      MODE_PLAIN = 4'b0001,
      MODE_ESC   = 4'b0010,
      MODE_OCT1  = 4'b0100,
      MODE_OCT2  = 4'b1000
   } mode_type;

   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CTL_HT    = 8'h09;
   localparam logic [7:0] CTL_BS    = 8'h08;
   localparam logic [7:0] CTL_FF    = 8'h0C;
   localparam logic [4:0] OCT_PREFIX = 5'b00110;

endpackage

/* rtl/core/pdf_literal_string_decoder_core.sv */
// ----------------------------------------------------------------------------
// pdf_literal_string_decoder_core
// Decodes a PDF literal string body, one raw byte per transfer.
//
//   channel  dir  payload             transfer when
//   req      in   plsd_pkg::req_type  req_valid & !req_stall
//   rsp      out  plsd_pkg::rsp_type  rsp_valid & !rsp_stall
//
// One byte per cycle while the result queue has room; a byte passes the input
// register, then the decode writes the result queue, which drives rsp directly.
// A byte other than a backslash that closes a short octal run gives two
// results; the queue absorbs them.
// Synchronous reset clears decode state and the queue.
// rsp_stall backs up into req_stall once the queue holds three results.
// ----------------------------------------------------------------------------
module pdf_literal_string_decoder_core #(
   parameter int DEPTH_BITS = plsd_pkg::DEPTH_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plsd_pkg::rsp_type rsp_data
);

   logic              in_vld_ff, in_vld_in;
   plsd_pkg::req_type in_ff;
   logic              room, fire, take;
   plsd_pkg::rsp_type res0, res1;
   logic [1:0]        res_count;

   assign fire      = in_vld_ff & room;
   assign req_stall = in_vld_ff & ~room;
   assign take      = req_valid & ~req_stall;
   assign in_vld_in = take | (in_vld_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
   end

   plsd_decode #(
      .DEPTH_BITS(DEPTH_BITS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (in_ff),
      .res0     (res0),
      .res1     (res1),
      .res_count(res_count)
   );

   plsd_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push_count(fire ? res_count : 2'd0),
      .push0     (res0),
      .push1     (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/plsd_decode.sv */
// ----------------------------------------------------------------------------
// plsd_decode
// Escape, octal and nesting state with the decode logic for one byte.
// ----------------------------------------------------------------------------
module plsd_decode #(
   parameter int DEPTH_BITS = plsd_pkg::DEPTH_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  plsd_pkg::req_type item,
   output plsd_pkg::rsp_type res0,
   output plsd_pkg::rsp_type res1,
   output logic [1:0]        res_count
);

   plsd_pkg::mode_type    mode_ff, mode_in;
   logic [5:0]            oct_ff, oct_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;

   logic [7:0]            c;
   logic                  is_oct;
   logic [8:0]            oct_sum;
   logic                  rearm;

   logic                  p_emit, p_done, p_esc;
   logic [2:0]            p_status;
   logic [DEPTH_BITS-1:0] p_depth;
   plsd_pkg::rsp_type     p_res;

   function automatic plsd_pkg::rsp_type make_rsp(logic [7:0] b, logic v, logic d,
                                                  logic [2:0] s);
      plsd_pkg::rsp_type r;
      r.out_byte   = v ? b : 8'd0;
      r.byte_valid = v;
      r.done_res   = d;
      r.status     = s;
      r.last       = 1'b0;
      return r;
   endfunction

   assign c       = item.in_byte;
   assign is_oct  = (c[7:3] == plsd_pkg::OCT_PREFIX);
   assign oct_sum = {oct_ff, c[2:0]};

   // plain-text handling of the current byte
   always_comb begin
      p_emit   = 1'b0;
      p_done   = 1'b0;
      p_esc    = 1'b0;
      p_status = plsd_pkg::STATUS_OK;
      p_depth  = depth_ff;
      if (c == plsd_pkg::CH_CLOSE) begin
         if (depth_ff != '0) begin
            p_depth = depth_ff - 1'b1;
            p_emit  = 1'b1;
         end else begin
            p_done = 1'b1;
         end
      end else if (c == plsd_pkg::CH_OPEN) begin
         if (&depth_ff) begin
            p_done   = 1'b1;
            p_status = plsd_pkg::STATUS_NEST;
         end else begin
            p_depth = depth_ff + 1'b1;
            p_emit  = 1'b1;
         end
      end else if (c == plsd_pkg::CH_BSLASH) begin
         p_esc = 1'b1;
      end else begin
         p_emit = 1'b1;
      end
      p_res = make_rsp(c, p_emit, p_done, p_status);
   end

   always_comb begin
      res0      = make_rsp(8'd0, 1'b0, 1'b0, plsd_pkg::STATUS_OK);
      res1      = make_rsp(8'd0, 1'b0, 1'b0, plsd_pkg::STATUS_OK);
      res_count = 2'd0;
      mode_in   = mode_ff;
      oct_in    = oct_ff;
      depth_in  = depth_ff;
      rearm     = 1'b0;
      if (item.end_of_input) begin
         res0      = make_rsp(8'd0, 1'b0, 1'b1, plsd_pkg::STATUS_EOI);
         res_count = 2'd1;
         rearm     = 1'b1;
      end else begin
         case (mode_ff)
            plsd_pkg::MODE_PLAIN: begin
               if (p_esc) begin
                  mode_in = plsd_pkg::MODE_ESC;
               end else begin
                  res0      = p_res;
                  res_count = 2'd1;
                  depth_in  = p_depth;
                  rearm     = p_done;
               end
            end
            plsd_pkg::MODE_ESC: begin
               mode_in   = plsd_pkg::MODE_PLAIN;
               res_count = 2'd1;
               case (c)
                  plsd_pkg::CH_N: res0 = make_rsp(plsd_pkg::CH_LF, 1'b1, 1'b0,
                                                  plsd_pkg::STATUS_OK);
                  plsd_pkg::CH_R: res0 = make_rsp(plsd_pkg::CH_CR, 1'b1, 1'b0,
                                                  plsd_pkg::STATUS_OK);
                  plsd_pkg::CH_T: res0 = make_rsp(plsd_pkg::CTL_HT, 1'b1, 1'b0,
                                                  plsd_pkg::STATUS_OK);
                  plsd_pkg::CH_B: res0 = make_rsp(plsd_pkg::CTL_BS, 1'b1, 1'b0,
                                                  plsd_pkg::STATUS_OK);
                  plsd_pkg::CH_F: res0 = make_rsp(plsd_pkg::CTL_FF, 1'b1, 1'b0,
                                                  plsd_pkg::STATUS_OK);
                  plsd_pkg::CH_OPEN, plsd_pkg::CH_CLOSE, plsd_pkg::CH_BSLASH:
                     res0 = make_rsp(c, 1'b1, 1'b0, plsd_pkg::STATUS_OK);
                  plsd_pkg::CH_CR, plsd_pkg::CH_LF: res_count = 2'd0;
                  default: begin
                     if (is_oct) begin
                        res_count = 2'd0;
                        oct_in    = {3'd0, c[2:0]};
                        mode_in   = plsd_pkg::MODE_OCT1;
                     end else begin
                        res0  = make_rsp(8'd0, 1'b0, 1'b1, plsd_pkg::STATUS_BAD_ESC);
                        rearm = 1'b1;
                     end
                  end
               endcase
            end
            plsd_pkg::MODE_OCT1, plsd_pkg::MODE_OCT2: begin
               if (is_oct) begin
                  if (mode_ff == plsd_pkg::MODE_OCT1) begin
                     oct_in  = oct_sum[5:0];
                     mode_in = plsd_pkg::MODE_OCT2;
                  end else begin
                     mode_in   = plsd_pkg::MODE_PLAIN;
                     oct_in    = 6'd0;
                     res_count = 2'd1;
                     if (oct_sum[8]) begin
                        res0  = make_rsp(8'd0, 1'b0, 1'b1, plsd_pkg::STATUS_OCTAL);
                        rearm = 1'b1;
                     end else begin
                        res0 = make_rsp(oct_sum[7:0], 1'b1, 1'b0, plsd_pkg::STATUS_OK);
                     end
                  end
               end else begin
                  // short octal run: flush it, then the byte as plain text
                  res0      = make_rsp({2'd0, oct_ff}, 1'b1, 1'b0, plsd_pkg::STATUS_OK);
                  res_count = 2'd1;
                  mode_in   = plsd_pkg::MODE_PLAIN;
                  oct_in    = 6'd0;
                  if (p_esc) begin
                     mode_in = plsd_pkg::MODE_ESC;
                  end else begin
                     res1      = p_res;
                     res_count = 2'd2;
                     depth_in  = p_depth;
                     rearm     = p_done;
                  end
               end
            end
            default: begin
               mode_in = plsd_pkg::MODE_PLAIN;
            end
         endcase
      end
      if (res_count == 2'd1) res0.last = 1'b1;
      if (res_count == 2'd2) res1.last = 1'b1;
      if (rearm) begin
         mode_in  = plsd_pkg::MODE_PLAIN;
         oct_in   = 6'd0;
         depth_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= plsd_pkg::MODE_PLAIN;
         oct_ff   <= 6'd0;
         depth_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         oct_ff   <= oct_in;
         depth_ff <= depth_in;
      end
   end

endmodule

/* rtl/core/plsd_rspq.sv */
// ----------------------------------------------------------------------------
// plsd_rspq
// Four-entry result queue; takes up to two results a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module plsd_rspq (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_count,
   input  plsd_pkg::rsp_type push0,
   input  plsd_pkg::rsp_type push1,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plsd_pkg::rsp_type rsp_data
);

   localparam int QDEPTH = 4;
   localparam int PW     = $clog2(QDEPTH);

   plsd_pkg::rsp_type mem_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              pop;

   assign room      = (count_ff <= (PW+1)'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;

   assign wr_ptr_in = wr_ptr_ff + PW'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + (PW+1)'(push_count) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_ptr_ff + PW'(1)] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/plsd_checker.sv */
// ----------------------------------------------------------------------------
// plsd_checker
// Port-level checks of the PDF literal string decoder.
// ----------------------------------------------------------------------------
module plsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input plsd_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.out_byte == 8'd0)
      else $error("out_byte set without byte_valid");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != plsd_pkg::STATUS_OK
         |-> rsp_data.done_res && !rsp_data.byte_valid)
      else $error("error status without done");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.last)
      else $error("done result not last of its transfer");

endmodule

bind pdf_literal_string_decoder_core plsd_checker u_plsd_checker (.*);
